// ===== sv/udprx_pkg.sv =====
// Package for the UDP receive checker: item and result types, codes and constants.
// Shared by the interfaces, the datagram tracker, the verdict logic and the top level.
package udprx_pkg;

   localparam int PORT_REGS   = 4;
   localparam int SLOT_W      = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int FIFO_DEPTH  = 4;

   localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
   localparam logic [15:0] UDP_PROTO     = 16'd17;
   localparam logic [15:0] POS_SATURATED = 16'hFFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOCAL_IP  = 3'd0,
      CSR_PORT_0    = 3'd1,
      CSR_PORT_1    = 3'd2,
      CSR_PORT_2    = 3'd3,
      CSR_PORT_3    = 3'd4,
      CSR_SLOT_MASK = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_SHORT       = 2'd0,
      VERDICT_BAD_SUM     = 2'd1,
      VERDICT_DELIVERED   = 2'd2,
      VERDICT_UNREACHABLE = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [31:0] sender_ip;
      logic [7:0]  data_byte;
      logic        end_of_datagram;
   } item_type;

   // Everything the verdict logic needs once the final byte has been folded in.
   typedef struct packed {
      logic [15:0] sum;
      logic [7:0]  tail_byte;
      logic        odd_count;
      logic        short_count;
      logic [15:0] sender_sum;
      logic [15:0] length;
      logic [15:0] source_port;
      logic [15:0] dst_port;
      logic [15:0] checksum;
   } finish_type;

   typedef struct packed {
      verdict_type       verdict;
      logic [SLOT_W-1:0] matched_slot;
      logic [15:0]       source_port;
      logic [15:0]       payload_length;
   } result_type;

   // Ones'-complement add with end-around carry.
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

// ===== sv/udprx_if.sv =====
// Handshake channel interfaces of the UDP receive checker: datagram bytes in,
// verdicts out, and the register write port. Depends on udprx_pkg for widths.
interface udprx_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sender_ip;
   logic [7:0]  data_byte;
   logic        end_of_datagram;

   modport source (output valid, sender_ip, data_byte, end_of_datagram, input ready);
   modport sink   (input valid, sender_ip, data_byte, end_of_datagram, output ready);
endinterface

interface udprx_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [1:0]  matched_slot;
   logic [15:0] source_port;
   logic [15:0] payload_length;

   modport source (output valid, verdict, matched_slot, source_port, payload_length,
                   input ready);
   modport sink   (input valid, verdict, matched_slot, source_port, payload_length,
                   output ready);
endinterface

interface udprx_csr_if;
   import udprx_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/udprx_datagram.sv =====
// Per-datagram tracker: captures the UDP header and keeps the running checksum.
// On the final byte it hands a finish record to the verdict logic. Uses udprx_pkg.
module udprx_datagram (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  udprx_pkg::item_type   item,
   output logic                  fin_valid,
   output udprx_pkg::finish_type fin
);
   import udprx_pkg::*;

   logic [15:0] pos_ff, pos_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  pend_ff, pend_in;
   logic [15:0] src_ff, src_in;
   logic [15:0] dst_ff, dst_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] csum_ff, csum_in;
   logic [15:0] ssum_ff, ssum_in;
   logic        fin_valid_ff, fin_valid_in;
   finish_type  fin_ff, fin_in;
   logic [7:0]  cb;

   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      pend_in = pend_ff;
      src_in  = src_ff;
      dst_in  = dst_ff;
      len_in  = len_ff;
      csum_in = csum_ff;
      ssum_in = ssum_ff;
      cb      = item.data_byte;
      if (item_valid && pos_ff != POS_SATURATED) begin
         if (pos_ff < UDP_HDR_BYTES) begin
            case (pos_ff[2:0])
               3'd0: src_in[15:8]  = item.data_byte;
               3'd1: src_in[7:0]   = item.data_byte;
               3'd2: dst_in[15:8]  = item.data_byte;
               3'd3: dst_in[7:0]   = item.data_byte;
               3'd4: len_in[15:8]  = item.data_byte;
               3'd5: len_in[7:0]   = item.data_byte;
               3'd6: begin
                  csum_in[15:8] = item.data_byte;
                  cb = 8'd0;
               end
               default: begin
                  csum_in[7:0] = item.data_byte;
                  cb = 8'd0;
               end
            endcase
         end
         if (pos_ff == 16'd0) begin
            ssum_in = oc_add(item.sender_ip[31:16], item.sender_ip[15:0]);
         end
         if (!pos_ff[0]) begin
            pend_in = cb;
         end else begin
            sum_in = oc_add(sum_ff, {pend_ff, cb});
         end
         pos_in = pos_ff + 16'd1;
      end
   end

   always_comb begin
      fin_valid_in       = item_valid && item.end_of_datagram;
      fin_in.sum         = sum_in;
      fin_in.tail_byte   = pend_in;
      fin_in.odd_count   = pos_in[0];
      fin_in.short_count = pos_in < UDP_HDR_BYTES;
      fin_in.sender_sum  = ssum_in;
      fin_in.length      = len_in;
      fin_in.source_port = src_in;
      fin_in.dst_port    = dst_in;
      fin_in.checksum    = csum_in;
   end

   always_ff @(posedge clock) begin
      if (reset || fin_valid_in) begin
         pos_ff  <= '0;
         sum_ff  <= '0;
         pend_ff <= '0;
         src_ff  <= '0;
         dst_ff  <= '0;
         len_ff  <= '0;
         csum_ff <= '0;
         ssum_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         pend_ff <= pend_in;
         src_ff  <= src_in;
         dst_ff  <= dst_in;
         len_ff  <= len_in;
         csum_ff <= csum_in;
         ssum_ff <= ssum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
      fin_ff <= fin_in;
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule

// ===== sv/udprx_verdict.sv =====
// Verdict logic: folds the pseudo header into the datagram sum, checks it against
// the received checksum and searches the port table. Uses udprx_pkg.
module udprx_verdict #(
   parameter int HANDLER_SLOTS = 4
) (
   input  udprx_pkg::finish_type              fin,
   input  logic [15:0]                         local_sum,
   input  logic [udprx_pkg::PORT_REGS-1:0]     slot_enable,
   input  logic [udprx_pkg::PORT_REGS-1:0][15:0] port_entry,
   output udprx_pkg::result_type               result
);
   import udprx_pkg::*;

   logic [18:0]       total;
   logic [16:0]       fold1;
   logic [15:0]       folded;
   logic [15:0]       computed;
   logic [15:0]       tail_word;
   logic              found;
   logic [SLOT_W-1:0] slot;

   always_comb begin
      tail_word = fin.odd_count ? {fin.tail_byte, 8'd0} : 16'd0;
      total = 19'(fin.sum) + 19'(tail_word) + 19'(fin.sender_sum) + 19'(local_sum)
            + 19'(fin.length);
      fold1    = {1'b0, total[15:0]} + {14'd0, total[18:16]};
      folded   = fold1[15:0] + {15'd0, fold1[16]};
      computed = ~folded;
   end

   always_comb begin
      found = 1'b0;
      slot  = '0;
      for (int i = 0; i < PORT_REGS; i++) begin
         if (i < HANDLER_SLOTS && !found && slot_enable[i] && port_entry[i] == fin.dst_port)
         begin
            found = 1'b1;
            slot  = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      result.source_port    = fin.source_port;
      result.matched_slot   = '0;
      result.payload_length = '0;
      if (fin.length < UDP_HDR_BYTES || fin.short_count) begin
         result.verdict = VERDICT_SHORT;
      end else if (computed != fin.checksum) begin
         result.verdict = VERDICT_BAD_SUM;
      end else if (found) begin
         result.verdict        = VERDICT_DELIVERED;
         result.matched_slot   = slot;
         result.payload_length = fin.length - UDP_HDR_BYTES;
      end else begin
         result.verdict = VERDICT_UNREACHABLE;
      end
   end

endmodule

// ===== sv/udp_receive_check_and_port_demux.sv =====
// UDP receive checker: takes one datagram byte per item at one item per clock while
// req ready is high, and gives one verdict per datagram. An accepted byte enters the
// input register, the next cycle folds it into the header capture and running
// checksum, and on the final byte the finish record is registered, the verdict is
// computed from it and written into a four-entry result queue, whose head is offered. The queue
// decouples the two sides; req ready falls only when queued and in-flight verdicts
// already fill it. Depends on udprx_pkg, the channel interfaces, udprx_datagram and
// udprx_verdict.
module udp_receive_check_and_port_demux #(
   parameter int HANDLER_SLOTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   udprx_req_if.sink   req_bus,
   udprx_rsp_if.source rsp_bus,
   udprx_csr_if.sink   csr_bus
);
   import udprx_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic                         s1_valid_ff;
   item_type                     s1_item_ff;
   logic                         req_accept;
   logic                         fin_valid;
   finish_type                   fin;
   result_type                   result;

   logic [15:0]                  local_sum_ff;
   logic [PORT_REGS-1:0][15:0]   port_entry_ff;
   logic [PORT_REGS-1:0]         slot_enable_ff;
   logic [1:0]                   port_sel;

   result_type                   fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]             wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W:0]               committed;
   logic                         pop;

   // Register port.
   assign csr_bus.ready = 1'b1;
   assign port_sel      = 2'(csr_bus.index - CSR_PORT_0);

   always_ff @(posedge clock) begin
      if (reset) begin
         local_sum_ff   <= UDP_PROTO;
         port_entry_ff  <= '0;
         slot_enable_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index) inside
            CSR_LOCAL_IP: begin
               local_sum_ff <= oc_add(oc_add(csr_bus.data[31:16], csr_bus.data[15:0]),
                                      UDP_PROTO);
            end
            CSR_PORT_0, CSR_PORT_1, CSR_PORT_2, CSR_PORT_3: begin
               port_entry_ff[port_sel] <= csr_bus.data[15:0];
            end
            CSR_SLOT_MASK: begin
               slot_enable_ff <= csr_bus.data[PORT_REGS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input register; ready is held back only by result queue space.
   assign committed = (CNT_W+1)'(count_ff)
                    + (CNT_W+1)'(s1_valid_ff && s1_item_ff.end_of_datagram)
                    + (CNT_W+1)'(fin_valid);
   assign req_bus.ready = committed < (CNT_W+1)'(FIFO_DEPTH);
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s1_item_ff.sender_ip       <= req_bus.sender_ip;
         s1_item_ff.data_byte       <= req_bus.data_byte;
         s1_item_ff.end_of_datagram <= req_bus.end_of_datagram;
      end
   end

   udprx_datagram u_datagram (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item       (s1_item_ff),
      .fin_valid  (fin_valid),
      .fin        (fin)
   );

   udprx_verdict #(
      .HANDLER_SLOTS (HANDLER_SLOTS)
   ) u_verdict (
      .fin         (fin),
      .local_sum   (local_sum_ff),
      .slot_enable (slot_enable_ff),
      .port_entry  (port_entry_ff),
      .result      (result)
   );

   // Result queue.
   assign pop      = rsp_bus.valid && rsp_bus.ready;
   assign count_in = count_ff + CNT_W'(fin_valid) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (fin_valid) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
      if (fin_valid) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_bus.valid          = count_ff != '0;
   assign rsp_bus.verdict        = fifo_ff[rd_ptr_ff].verdict;
   assign rsp_bus.matched_slot   = fifo_ff[rd_ptr_ff].matched_slot;
   assign rsp_bus.source_port    = fifo_ff[rd_ptr_ff].source_port;
   assign rsp_bus.payload_length = fifo_ff[rd_ptr_ff].payload_length;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fin_valid |-> (count_ff != CNT_W'(FIFO_DEPTH)) || pop)
      else $error("Result queue written while full.");

   a_final_byte_reaches_verdict: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_item_ff.end_of_datagram |=> fin_valid)
      else $error("Final byte did not produce a verdict.");

   a_only_delivered_has_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.verdict != VERDICT_DELIVERED
         |-> rsp_bus.matched_slot == '0 && rsp_bus.payload_length == '0)
      else $error("Slot or payload length given for an undelivered datagram.");

   a_count_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("Result queue count out of range.");

endmodule
